FILE: design/infix_expression_evaluator_core_defines.svh
// assertion macros for the infix expression evaluator
// used by the top level; expects clk and arst_n in scope
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define IEV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IEV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/iev_pkg.sv
// shared types, constants and helper functions of the infix evaluator
// no dependencies
package iev_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int CHAR_W      = 8;
	localparam int RESULT_W    = 32;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'd42;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'd47;
	localparam logic [CHAR_W-1:0] CHAR_EQUAL = 8'd61;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [2:0] {
		CK_DIGIT,
		CK_ADD,
		CK_SUB,
		CK_MUL,
		CK_DIV,
		CK_EQ,
		CK_OTHER
	} char_kind_t;

	// request to the shared multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	// status back from the shared unit
	typedef struct packed {
		logic done;
		logic div_zero;
	} md_rsp_t;

	function automatic char_kind_t classify(input logic [CHAR_W-1:0] c);
		char_kind_t k;
		k = CK_OTHER;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) k = CK_DIGIT;
		else if (c == CHAR_PLUS)  k = CK_ADD;
		else if (c == CHAR_MINUS) k = CK_SUB;
		else if (c == CHAR_STAR)  k = CK_MUL;
		else if (c == CHAR_SLASH) k = CK_DIV;
		else if (c == CHAR_EQUAL) k = CK_EQ;
		return k;
	endfunction

	function automatic value_t magnitude(input value_t v);
		value_t m;
		m = v[VALUE_WIDTH-1] ? value_t'('0 - v) : v;
		return m;
	endfunction

	// sign-extend or cut the internal value to the result width
	function automatic logic signed [RESULT_W-1:0] to_result(input value_t v);
		logic signed [RESULT_W-1:0] r;
		int idx;
		r = '0;
		for (int i = 0; i < RESULT_W; i++) begin
			idx = (i < VALUE_WIDTH) ? i : VALUE_WIDTH - 1;
			r[i] = v[idx];
		end
		return r;
	endfunction

endpackage

FILE: design/iev_char_if.sv
// input channel of the evaluator: one ascii character per word
// depends on iev_pkg
interface iev_char_if;
	import iev_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

FILE: design/iev_result_if.sv
// output channel of the evaluator: one result word per expression
// depends on iev_pkg
interface iev_result_if;
	import iev_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [RESULT_W-1:0] result_value;
	logic                       divide_by_zero;

	modport source (output valid, output result_value, output divide_by_zero, input ready);
	modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

FILE: design/iev_muldiv.sv
// shared iterative multiply / signed divide unit, one bit per cycle
// depends on iev_pkg
module iev_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  iev_pkg::md_req_t req,
	input  iev_pkg::value_t  a,
	input  iev_pkg::value_t  b,
	output iev_pkg::md_rsp_t rsp,
	output iev_pkg::value_t  result
);
	import iev_pkg::*;

	typedef enum logic [1:0] {
		M_IDLE,
		M_RUN,
		M_FIN
	} md_state_t;

	md_state_t         state_q;
	logic              is_div_q;
	logic              neg_q;
	value_t            dvs_q;
	value_t            shf_q;
	value_t            acc_q;
	logic [CNT_W-1:0]  cnt_q;
	value_t            res_q;
	logic              done_q;
	logic              dz_q;

	logic [VALUE_WIDTH:0]   add_x;
	logic [VALUE_WIDTH:0]   add_y;
	logic [VALUE_WIDTH+1:0] add_sum;
	logic                   geq;

	// one adder: accumulate for multiply, trial subtract for divide
	always_comb begin
		add_x   = is_div_q ? {acc_q, shf_q[VALUE_WIDTH-1]} : {1'b0, acc_q};
		add_y   = is_div_q ? ~{1'b0, dvs_q} : {1'b0, dvs_q};
		add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(VALUE_WIDTH+1){1'b0}}, is_div_q};
		geq     = add_sum[VALUE_WIDTH+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			is_div_q <= 1'b0;
			neg_q    <= 1'b0;
			dvs_q    <= '0;
			shf_q    <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			res_q    <= '0;
			done_q   <= 1'b0;
			dz_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						is_div_q <= req.is_div;
						acc_q    <= '0;
						cnt_q    <= CNT_W'(VALUE_WIDTH);
						if (req.is_div) begin
							if (b == '0) begin
								res_q  <= '0;
								dz_q   <= 1'b1;
								done_q <= 1'b1;
							end else begin
								dvs_q   <= magnitude(b);
								shf_q   <= magnitude(a);
								neg_q   <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
								state_q <= M_RUN;
							end
						end else begin
							dvs_q   <= a;
							shf_q   <= b;
							neg_q   <= 1'b0;
							state_q <= M_RUN;
						end
					end
				end
				M_RUN: begin
					if (is_div_q) begin
						acc_q <= geq ? add_sum[VALUE_WIDTH-1:0] : add_x[VALUE_WIDTH-1:0];
						shf_q <= {shf_q[VALUE_WIDTH-2:0], geq};
					end else begin
						if (shf_q[0]) acc_q <= add_sum[VALUE_WIDTH-1:0];
						dvs_q <= dvs_q << 1;
						shf_q <= shf_q >> 1;
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) state_q <= M_FIN;
				end
				M_FIN: begin
					if (is_div_q) res_q <= neg_q ? value_t'('0 - shf_q) : shf_q;
					else          res_q <= acc_q;
					dz_q    <= 1'b0;
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign result       = res_q;

endmodule

FILE: design/infix_expression_evaluator_core.sv
// infix expression evaluator top level; depends on iev_pkg, the channel interfaces, iev_muldiv
// digit: taken in the idle state; + - * / = with no pending multiply or divide: S_AFTER
// then idle; operator closing a pending * or /: waits in S_NUM on the bit-serial shared
// multiply/divide unit, which skips its run on a zero divisor; '=' adds the S_EMIT state
// to load the output register
// the result sits in an output register, so a new character is taken while it waits
// arst_n clears all evaluation state and the output valid; the block then takes a new expression
`include "infix_expression_evaluator_core_defines.svh"

module infix_expression_evaluator_core (
	input  logic         clk,
	input  logic         arst_n,
	iev_char_if.sink     char_in,
	iev_result_if.source result_out
);
	import iev_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,   // taking characters
		S_NUM,    // waiting on the shared multiply/divide unit
		S_AFTER,  // folding the term and latching the operator
		S_EMIT    // loading the result word
	} state_t;

	// pending multiplicative operator
	typedef enum logic [1:0] {
		MOP_NEW = 2'd0,
		MOP_MUL = 2'd1,
		MOP_DIV = 2'd2
	} mul_op_t;

	state_t     state_q;
	char_kind_t op_q;
	value_t     num_q;      // number being typed
	value_t     sum_q;      // finished additive terms
	value_t     prod_q;     // current product term
	mul_op_t    mop_q;
	logic       sub_q;      // subtract the current term
	logic       zero_q;     // zero divisor met in this expression

	logic                       out_valid_q;
	logic signed [RESULT_W-1:0] out_value_q;
	logic                       out_dz_q;

	char_kind_t kind;
	logic       accept;
	logic       closes_number;
	logic       md_pending;
	value_t     term_sum;
	logic [3:0] digit;
	logic       emit_load;

	md_req_t    md_req;
	md_rsp_t    md_rsp;
	value_t     md_result;

	assign char_in.ready = (state_q == S_IDLE);
	assign accept        = char_in.valid && char_in.ready;
	assign kind          = classify(char_in.char_code);
	assign digit         = 4'(char_in.char_code - CHAR_ZERO);

	// any operator or '=' ends the number being typed
	assign closes_number = (kind == CK_ADD) || (kind == CK_SUB) || (kind == CK_MUL)
		|| (kind == CK_DIV) || (kind == CK_EQ);
	assign md_pending    = (mop_q == MOP_MUL) || (mop_q == MOP_DIV);

	// number feeds the unit straight from its register on the accept edge
	assign md_req.start  = accept && closes_number && md_pending;
	assign md_req.is_div = (mop_q == MOP_DIV);

	// fold the product term into the running sum
	assign term_sum = sub_q ? value_t'(sum_q - prod_q) : value_t'(sum_q + prod_q);

	// output register is free or being emptied this cycle
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || result_out.ready);

	iev_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (prod_q),
		.b      (num_q),
		.rsp    (md_rsp),
		.result (md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= CK_OTHER;
			num_q       <= '0;
			sum_q       <= '0;
			prod_q      <= '0;
			mop_q       <= MOP_NEW;
			sub_q       <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_dz_q    <= 1'b0;
		end else begin
			// a new word being loaded keeps valid high
			if (out_valid_q && result_out.ready && !emit_load) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == CK_DIGIT) begin
							// n * 10 + d as two shifts and adds, wrapping
							num_q <= value_t'((num_q << 3) + (num_q << 1)
								+ value_t'(digit));
						end else if (closes_number) begin
							op_q <= kind;
							if (md_pending) begin
								state_q <= S_NUM;
							end else begin
								prod_q  <= num_q;
								num_q   <= '0;
								state_q <= S_AFTER;
							end
						end
					end
				end
				S_NUM: begin
					if (md_rsp.done) begin
						prod_q  <= md_result;
						num_q   <= '0;
						if (md_rsp.div_zero) zero_q <= 1'b1;
						state_q <= S_AFTER;
					end
				end
				S_AFTER: begin
					case (op_q)
						CK_ADD, CK_SUB: begin
							sum_q   <= term_sum;
							prod_q  <= '0;
							sub_q   <= (op_q == CK_SUB);
							mop_q   <= MOP_NEW;
							state_q <= S_IDLE;
						end
						CK_MUL: begin
							mop_q   <= MOP_MUL;
							state_q <= S_IDLE;
						end
						CK_DIV: begin
							mop_q   <= MOP_DIV;
							state_q <= S_IDLE;
						end
						CK_EQ: begin
							sum_q   <= term_sum;
							prod_q  <= '0;
							state_q <= S_EMIT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						out_value_q <= to_result(sum_q);
						out_dz_q    <= zero_q;
						// clear for the next expression
						num_q       <= '0;
						sum_q       <= '0;
						prod_q      <= '0;
						mop_q       <= MOP_NEW;
						sub_q       <= 1'b0;
						zero_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.result_value   = out_value_q;
	assign result_out.divide_by_zero = out_dz_q;

	// the shared unit answers only while the sequencer waits on it
	`IEV_ASSERT_IMPL(a_md_done_in_wait, md_rsp.done, state_q == S_NUM, "muldiv done outside wait")

	// a started multiply or divide holds off the input side
	`IEV_ASSERT_NEXT(a_md_start_blocks, md_req.start, !char_in.ready, "input ready during muldiv")

	// loading a result clears the evaluation state
	`IEV_ASSERT_NEXT(a_emit_clears, emit_load, (sum_q == '0) && !zero_q && out_valid_q, "kept state")

endmodule

FILE: tb/testbench.sv
// self-checking bench for infix_expression_evaluator_core: drives ascii words and checks results
// depends on iev_pkg, iev_char_if, iev_result_if and the core; evaluates expressions on the side
module testbench;
	import iev_pkg::*;

	typedef enum logic [1:0] {
		TERM_NEW,
		TERM_MUL,
		TERM_DIV
	} term_op_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] value;
		logic                       div_zero;
	} expr_res_t;

	typedef struct {
		string     text;
		bit        pinned;
		expr_res_t want;
	} drill_row_t;

	localparam int RAND_TOKENS = 1810;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = VALUE_WIDTH + 8;
	localparam value_t DEC_RADIX = 10;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = " ";
	// a string cannot carry a nul, so this mark stands for one in the drill table
	localparam logic [CHAR_W-1:0] NUL_MARK = "#";
	localparam logic signed [RESULT_W-1:0] MOST_NEG = {1'b1, {(RESULT_W-1){1'b0}}};

	localparam int SEND_IDLE[3] = '{13, 74, 0};
	localparam int RECV_IDLE[3] = '{74, 13, 0};

	logic clk;
	logic arst_n;

	iev_char_if   char_ch ();
	iev_result_if res_ch ();

	infix_expression_evaluator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_ch),
		.result_out(res_ch)
	);

	// side evaluator state
	value_t   acc_num;
	value_t   acc_sum;
	value_t   acc_term;
	term_op_t term_op;
	logic     term_sub;
	logic     zdiv_seen;

	expr_res_t pending_results[$];
	expr_res_t got;
	expr_res_t want;
	logic [CHAR_W-1:0] expr_text[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  pin_on;
	expr_res_t pin_want;
	int  mismatches;
	int  results_checked;
	int  zdiv_results;
	int  tokens_sent;
	int  expr_count;
	string sym_set = "0123456789+-*/=";

	drill_row_t drills[4] = '{
		'{"=", 1'b1, '{value: '0, div_zero: 1'b0}},
		'{"#7+2*9\377=", 1'b1, '{value: 25, div_zero: 1'b0}},
		'{"9-0/0--*4=", 1'b0, '{value: '0, div_zero: 1'b0}},
		'{"2147483648/8589934591=", 1'b1, '{value: MOST_NEG, div_zero: 1'b0}}
	};

	function automatic void clear_eval();
		acc_num   = '0;
		acc_sum   = '0;
		acc_term  = '0;
		term_op   = TERM_NEW;
		term_sub  = 1'b0;
		zdiv_seen = 1'b0;
	endfunction

	// close the number just typed into the product term
	function automatic void fold_number();
		value_t mag_n;
		value_t mag_d;
		value_t quo;
		case (term_op)
			TERM_MUL: acc_term = acc_term * acc_num;
			TERM_DIV: begin
				if (acc_num == '0) begin
					zdiv_seen = 1'b1;
					acc_term  = '0;
				end else begin
					mag_n = acc_term[VALUE_WIDTH-1] ? value_t'('0 - acc_term) : acc_term;
					mag_d = acc_num[VALUE_WIDTH-1] ? value_t'('0 - acc_num) : acc_num;
					quo   = mag_n / mag_d;
					// truncation toward zero, sign from the operands
					acc_term = (acc_term[VALUE_WIDTH-1] ^ acc_num[VALUE_WIDTH-1]) ?
						value_t'('0 - quo) : quo;
				end
			end
			default: acc_term = acc_num;
		endcase
		acc_num = '0;
	endfunction

	// close the product term into the running sum
	function automatic void fold_term();
		acc_sum  = term_sub ? acc_sum - acc_term : acc_sum + acc_term;
		acc_term = '0;
	endfunction

	// advance the evaluator by one character, returns 1 when a result comes out
	function automatic bit eval_char(input logic [CHAR_W-1:0] c, output expr_res_t r);
		r = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			acc_num = acc_num * DEC_RADIX + value_t'(c - CHAR_ZERO);
			return 1'b0;
		end
		case (c)
			CHAR_PLUS, CHAR_MINUS: begin
				fold_number();
				fold_term();
				term_sub = (c == CHAR_MINUS);
				term_op  = TERM_NEW;
			end
			CHAR_STAR, CHAR_SLASH: begin
				fold_number();
				term_op = (c == CHAR_STAR) ? TERM_MUL : TERM_DIV;
			end
			CHAR_EQUAL: begin
				fold_number();
				fold_term();
				r.value    = RESULT_W'($signed(acc_sum));
				r.div_zero = zdiv_seen;
				clear_eval();
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// a space or an arbitrary byte now and then between tokens
	function automatic void add_filler();
		if ($urandom_range(7) == 0)
			expr_text.push_back(($urandom_range(1) == 1) ? CHAR_SPACE :
				CHAR_W'($urandom_range(255)));
	endfunction

	// one random expression ending in '=', mostly well formed
	function automatic void build_expression();
		int n_terms;
		int n_dig;
		expr_text.delete();
		if ($urandom_range(9) == 0) begin
			// broken sequence: random digits, operators and bytes
			repeat ($urandom_range(14, 1))
				expr_text.push_back(($urandom_range(2) == 0) ? CHAR_W'($urandom_range(255)) :
					sym_set[$urandom_range(14)]);
		end else begin
			if ($urandom_range(9) == 0)
				expr_text.push_back(CHAR_MINUS);
			n_terms = $urandom_range(6, 1);
			for (int t = 0; t < n_terms; t++) begin
				if (t > 0) begin
					case ($urandom_range(3))
						0: expr_text.push_back(CHAR_PLUS);
						1: expr_text.push_back(CHAR_MINUS);
						2: expr_text.push_back(CHAR_STAR);
						default: expr_text.push_back(CHAR_SLASH);
					endcase
					add_filler();
				end
				case ($urandom_range(19))
					0: n_dig = 0;
					1, 2, 3: n_dig = -1;
					4, 5: n_dig = $urandom_range(12, 9);
					default: n_dig = $urandom_range(3, 1);
				endcase
				if (n_dig < 0)
					expr_text.push_back(CHAR_ZERO);
				for (int d = 0; d < n_dig; d++)
					expr_text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
				add_filler();
			end
		end
		expr_text.push_back(CHAR_EQUAL);
	endfunction

	// offer one word, with random gaps, and return once it is taken
	task automatic send_word(input logic [CHAR_W-1:0] c, input bit pin, input expr_res_t pw);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid     <= 1'b1;
		char_ch.char_code <= c;
		pin_on   = pin;
		pin_want = pw;
		if ((c >= CHAR_ZERO && c <= CHAR_NINE) ||
				c inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_EQUAL})
			tokens_sent++;
		do @(posedge clk); while (!char_ch.ready);
	endtask

	// stop offering and let every pending result come back
	task automatic drain_results();
		@(negedge clk);
		char_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// predict on every accepted character
	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (eval_char(char_ch.char_code, got)) begin
				// drill rows with a typed answer use it as the expectation
				pending_results.push_back(pin_on ? pin_want : got);
				expr_count++;
			end
		end
	end

	// receiver: random stalls, set at the falling edge
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending",
					res_ch.result_value));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.div_zero)
					zdiv_results++;
				if (res_ch.result_value !== want.value)
					report_mismatch($sformatf("result_value %0d, expected %0d",
						res_ch.result_value, want.value));
				if (res_ch.divide_by_zero !== want.div_zero)
					report_mismatch($sformatf("divide_by_zero %0b, expected %0b",
						res_ch.divide_by_zero, want.div_zero));
			end
		end
	end

	// watchdog: ends the run after too long without any word moving
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("infix_expression_evaluator_core test failed");
		$finish;
	end

	initial begin
		logic [CHAR_W-1:0] c;
		arst_n            = 1'b0;
		char_ch.valid     = 1'b0;
		char_ch.char_code = '0;
		res_ch.ready      = 1'b0;
		mismatches        = 0;
		results_checked   = 0;
		zdiv_results      = 0;
		tokens_sent       = 0;
		expr_count        = 0;
		pin_on            = 1'b0;
		pin_want          = '0;
		send_idle_pct     = SEND_IDLE[0];
		recv_idle_pct     = RECV_IDLE[0];
		clear_eval();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed drills
		foreach (drills[i]) begin
			for (int k = 0; k < drills[i].text.len(); k++) begin
				c = drills[i].text[k];
				if (c == NUL_MARK)
					c = '0;
				send_word(c, drills[i].pinned, drills[i].want);
			end
		end

		// random expressions in three idling phases, drained between phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			while (tokens_sent < (ph + 1) * RAND_TOKENS / 3) begin
				build_expression();
				foreach (expr_text[k])
					send_word(expr_text[k], 1'b0, '0);
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("covered %0d tokens in %0d expressions, %0d results checked",
			tokens_sent, expr_count, results_checked);
		$display("%0d results flagged a zero divisor, %0d mismatches",
			zdiv_results, mismatches);
		if (mismatches == 0)
			$display("infix_expression_evaluator_core test passed");
		else
			$display("infix_expression_evaluator_core test failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/iev_pkg.sv
design/iev_char_if.sv
design/iev_result_if.sv
design/iev_muldiv.sv
design/infix_expression_evaluator_core.sv
tb/testbench.sv
